// ===== rtl/spa_pkg.sv =====
// Package for the sparse paged array: widths, request codes, shared types.
`timescale 1ns / 1ps
package spa_pkg;
  localparam int FRAGS      = 32;
  localparam int CELLS      = 32;
  localparam int FRAG_W     = 5;
  localparam int OFF_W      = 5;
  localparam int ADDR_W     = FRAG_W + OFF_W;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = 10;
  localparam int CFG_W      = 6;
  localparam int CNT_W      = 11;

  typedef enum logic [2:0] {
    REQ_SET      = 3'd0,
    REQ_GET      = 3'd1,
    REQ_DELETE   = 3'd2,
    REQ_CONTAINS = 3'd3,
    REQ_ISSET    = 3'd4,
    REQ_CLEAR    = 3'd5
  } req_t;

  localparam logic CFG_FRAG_TOTAL = 1'b0;
  localparam logic CFG_CELLS      = 1'b1;

  // memory access request from control to the cell store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VALUE_W-1:0] wr_data;
  } mem_req_t;

  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] mx);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > mx) r = mx;
    return r;
  endfunction
endpackage

// ===== rtl/spa_store.sv =====
// Cell value memory: one write port and one registered read port.
`timescale 1ns / 1ps
module spa_store (
  input  logic                          clk,
  input  spa_pkg::mem_req_t             req,
  output logic [spa_pkg::VALUE_W-1:0]   rd_data
);
  import spa_pkg::*;
  logic [VALUE_W-1:0] mem [FRAGS*CELLS];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end
endmodule

// ===== rtl/spa_ctrl.sv =====
// Request sequencer: index split, valid bits, fill counts, scan and result.
`timescale 1ns / 1ps
module spa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_idx,
  input  logic [spa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_req_type,
  input  logic [spa_pkg::IDX_W-1:0]   in_cell_index,
  input  logic [spa_pkg::VALUE_W-1:0] in_key_value,
  output spa_pkg::mem_req_t           mreq,
  input  logic [spa_pkg::VALUE_W-1:0] rd_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [spa_pkg::VALUE_W-1:0] out_read_value,
  output logic                        out_hit,
  output logic [spa_pkg::CNT_W-1:0]   out_element_count,
  output logic [spa_pkg::CFG_W-1:0]   out_active_fragment_count,
  output logic [spa_pkg::CNT_W-1:0]   out_allocated_cells
);
  import spa_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_ACC, S_SCAN, S_LAST, S_OUT} st_t;

  st_t                st_r;
  logic [CFG_W-1:0]   ftot_r, cpf_r;
  logic [CELLS-1:0]   vbits_r [FRAGS];
  logic [CFG_W-1:0]   fill_r [FRAGS];
  logic [FRAGS-1:0]   act_r;
  logic [CNT_W-1:0]   tot_r;
  logic [CFG_W-1:0]   acnt_r;
  logic [2:0]         req_r;
  logic [IDX_W-1:0]   rem_r;
  logic [FRAG_W-1:0]  frag_r;
  logic [VALUE_W-1:0] key_r;
  logic [FRAG_W-1:0]  sf_r;
  logic [OFF_W-1:0]   sc_r;
  logic               sv_r;
  // result of the item in work, kept apart from a result still waiting at the output
  logic               sts_r;
  logic               hit_r;
  logic [VALUE_W-1:0] val_r;

  logic [FRAG_W-1:0]  fr;
  logic [OFF_W-1:0]   off;
  logic [CNT_W-1:0]   lim;
  logic               cell_v, in_rng;

  assign fr     = frag_r;
  assign off    = rem_r[OFF_W-1:0];
  assign lim    = CNT_W'(ftot_r * cpf_r);
  assign in_rng = CNT_W'(in_cell_index) < lim;
  assign cell_v = act_r[fr] && vbits_r[fr][off];
  assign in_stall = (st_r != S_IDLE);

  always_comb begin
    mreq = '0;
    mreq.wr_addr = {fr, off};
    mreq.wr_data = key_r;
    mreq.rd_addr = {fr, off};
    if (st_r == S_ACC && req_r == REQ_SET) mreq.wr_en = 1'b1;
    if (st_r == S_ACC && req_r == REQ_GET) mreq.rd_en = 1'b1;
    if (st_r == S_SCAN) begin
      mreq.rd_en   = 1'b1;
      mreq.rd_addr = {sf_r, sc_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ftot_r    <= CFG_W'(FRAGS);
      cpf_r     <= CFG_W'(CELLS);
      act_r     <= '0;
      tot_r     <= '0;
      acnt_r    <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < FRAGS; i++) fill_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_FRAG_TOTAL) ftot_r <= clamp_cfg(cfg_data, CFG_W'(FRAGS));
        else                           cpf_r  <= clamp_cfg(cfg_data, CFG_W'(CELLS));
        act_r  <= '0;
        tot_r  <= '0;
        acnt_r <= '0;
      end
      if (out_valid && !out_stall && st_r != S_OUT) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          req_r  <= in_req_type;
          key_r  <= in_key_value;
          rem_r  <= in_cell_index;
          frag_r <= '0;
          hit_r  <= 1'b0;
          val_r  <= '0;
          sf_r <= '0;
          sc_r <= '0;
          sv_r <= 1'b0;
          case (in_req_type)
            REQ_SET, REQ_GET, REQ_DELETE, REQ_ISSET: begin
              if (in_rng) begin
                sts_r <= 1'b0;
                st_r  <= S_DIV;
              end else begin
                sts_r <= 1'b1;
                st_r  <= S_OUT;
              end
            end
            REQ_CONTAINS: begin
              sts_r <= 1'b0;
              st_r  <= S_SCAN;
            end
            REQ_CLEAR: begin
              act_r  <= '0;
              tot_r  <= '0;
              acnt_r <= '0;
              sts_r  <= 1'b0;
              st_r   <= S_OUT;
            end
            default: begin
              sts_r <= 1'b1;
              st_r  <= S_OUT;
            end
          endcase
        end
        // one subtract per cycle: quotient below 32
        S_DIV: begin
          if (rem_r >= IDX_W'(cpf_r)) begin
            rem_r  <= rem_r - IDX_W'(cpf_r);
            frag_r <= frag_r + 1'b1;
          end else st_r <= S_ACC;
        end
        S_ACC: begin
          st_r <= S_OUT;
          case (req_r)
            REQ_SET: begin
              if (!act_r[fr]) begin
                act_r[fr]   <= 1'b1;
                acnt_r      <= acnt_r + 1'b1;
                vbits_r[fr] <= CELLS'(1) << off;
                fill_r[fr]  <= CFG_W'(1);
                tot_r       <= tot_r + 1'b1;
              end else if (!vbits_r[fr][off]) begin
                vbits_r[fr][off] <= 1'b1;
                fill_r[fr]      <= fill_r[fr] + 1'b1;
                tot_r           <= tot_r + 1'b1;
              end
            end
            REQ_GET: begin
              hit_r <= cell_v;
              if (cell_v) st_r <= S_LAST;
            end
            REQ_ISSET: hit_r <= cell_v;
            default: begin
              if (!cell_v) sts_r <= 1'b1;
              else begin
                vbits_r[fr][off] <= 1'b0;
                fill_r[fr]      <= fill_r[fr] - 1'b1;
                tot_r           <= tot_r - 1'b1;
                if (fill_r[fr] == CFG_W'(1)) begin
                  act_r[fr] <= 1'b0;
                  acnt_r    <= acnt_r - 1'b1;
                end
              end
            end
          endcase
        end
        // pipelined scan: address issued this cycle, data compared next
        S_SCAN: begin
          if (sv_r && rd_data == key_r) hit_r <= 1'b1;
          sv_r <= act_r[sf_r] && vbits_r[sf_r][sc_r];
          if (CFG_W'(sc_r) + 1'b1 >= cpf_r) begin
            sc_r <= '0;
            if (CFG_W'(sf_r) + 1'b1 >= ftot_r) st_r <= S_LAST;
            else sf_r <= sf_r + 1'b1;
          end else sc_r <= sc_r + 1'b1;
        end
        S_LAST: begin
          if (req_r == REQ_GET) val_r <= rd_data;
          else if (sv_r && rd_data == key_r) hit_r <= 1'b1;
          st_r <= S_OUT;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid                 <= 1'b1;
          out_status                <= sts_r;
          out_read_value            <= val_r;
          out_hit                   <= hit_r;
          out_element_count         <= tot_r;
          out_active_fragment_count <= acnt_r;
          out_allocated_cells       <= CNT_W'(acnt_r * cpf_r);
          st_r                      <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !in_stall) else $error("stall while idle");
  a_acnt: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r == CFG_W'($countones(act_r))) else $error("active count mismatch");
  a_tot: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r == '0 |-> tot_r == '0) else $error("elements without fragments");
  a_wr: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.wr_en |-> req_r == REQ_SET) else $error("stray write");
`endif
endmodule

// ===== rtl/sparse_paged_array.sv =====
// Top level of the sparse paged array.
`timescale 1ns / 1ps
// A 1024-cell sparse array in up to 32 fragments allocated on first set.
// One item at a time. Set, get, delete and is-set split the index by repeated
// subtraction, one subtraction per fragment passed; then set writes and get reads
// the cell memory, while delete and is-set use only the valid bits. Contains-key
// reads every cell of the configured fragments through the single memory read
// port. Clear and unknown codes go straight to the result. The next item is taken
// in the cycle after a result goes out; a result held at the output stalls the
// following item in its last step. A config write clears the contents.
module sparse_paged_array (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_idx,
  input  logic [spa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_req_type,
  input  logic [spa_pkg::IDX_W-1:0]   in_cell_index,
  input  logic [spa_pkg::VALUE_W-1:0] in_key_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_status,
  output logic [spa_pkg::VALUE_W-1:0] out_read_value,
  output logic                        out_hit,
  output logic [spa_pkg::CNT_W-1:0]   out_element_count,
  output logic [spa_pkg::CFG_W-1:0]   out_active_fragment_count,
  output logic [spa_pkg::CNT_W-1:0]   out_allocated_cells
);
  import spa_pkg::*;
  mem_req_t           mreq;
  logic [VALUE_W-1:0] rd_data;

  spa_store u_store (.clk(clk), .req(mreq), .rd_data(rd_data));

  spa_ctrl u_ctrl (.*);
endmodule

// ===== verif/tb_sparse_paged_array.sv =====
// Self-checking testbench for the sparse paged array: directed, config and random items.
`timescale 1ns / 1ps
module tb_sparse_paged_array;
  import spa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic              status;
    logic [VALUE_W-1:0] value;
    logic              hit;
    logic [CNT_W-1:0]  count;
    logic [CFG_W-1:0]  frags;
    logic [CNT_W-1:0]  alloc;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_req_type;
  logic [IDX_W-1:0] in_cell_index;
  logic [VALUE_W-1:0] in_key_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [VALUE_W-1:0] out_read_value;
  logic out_hit;
  logic [CNT_W-1:0] out_element_count;
  logic [CFG_W-1:0] out_active_fragment_count;
  logic [CNT_W-1:0] out_allocated_cells;

  sparse_paged_array uut (.*);

  // shadow copy of the array
  logic [VALUE_W-1:0] shadow_val [FRAGS][CELLS];
  bit shadow_on [FRAGS][CELLS];
  int shadow_fill [FRAGS];
  bit shadow_frag [FRAGS];
  int shadow_set;
  int shadow_frags;
  int frag_lim;
  int cell_lim;

  outcome_t pending_results[$];
  int error_count;
  int send_idle;
  int recv_idle;
  int hold_left = 0;
  bit hold_req;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void wipe_shadow();
    for (int f = 0; f < FRAGS; f++) begin
      shadow_fill[f] = 0;
      shadow_frag[f] = 0;
      for (int c = 0; c < CELLS; c++) shadow_on[f][c] = 0;
    end
    shadow_set = 0;
    shadow_frags = 0;
  endfunction

  function automatic int clamp_reg(int v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  function automatic outcome_t apply_request(logic [2:0] rq, logic [IDX_W-1:0] ix,
                                            logic [VALUE_W-1:0] kv);
    outcome_t r;
    int frag;
    int off;
    bit in_range;
    frag = ix / cell_lim;
    off = ix % cell_lim;
    in_range = ix < frag_lim * cell_lim;
    r.status = 0;
    r.value = '0;
    r.hit = 0;
    if (rq == REQ_SET || rq == REQ_GET || rq == REQ_DELETE || rq == REQ_ISSET) begin
      if (!in_range) begin
        r.status = 1;
      end else if (rq == REQ_SET) begin
        if (!shadow_frag[frag]) begin
          shadow_frag[frag] = 1;
          for (int c = 0; c < CELLS; c++) shadow_on[frag][c] = 0;
          shadow_fill[frag] = 0;
          shadow_frags++;
        end
        shadow_val[frag][off] = kv;
        if (!shadow_on[frag][off]) begin
          shadow_on[frag][off] = 1;
          shadow_fill[frag]++;
          shadow_set++;
        end
      end else if (rq == REQ_GET || rq == REQ_ISSET) begin
        if (shadow_frag[frag] && shadow_on[frag][off]) begin
          r.hit = 1;
          if (rq == REQ_GET) r.value = shadow_val[frag][off];
        end
      end else begin
        if (!shadow_frag[frag] || !shadow_on[frag][off]) begin
          r.status = 1;
        end else begin
          shadow_on[frag][off] = 0;
          shadow_fill[frag]--;
          shadow_set--;
          if (shadow_fill[frag] == 0) begin
            shadow_frag[frag] = 0;
            shadow_frags--;
          end
        end
      end
    end else if (rq == REQ_CONTAINS) begin
      for (int f = 0; f < frag_lim; f++)
        if (shadow_frag[f])
          for (int c = 0; c < cell_lim; c++)
            if (shadow_on[f][c] && shadow_val[f][c] == kv) r.hit = 1;
    end else if (rq == REQ_CLEAR) begin
      wipe_shadow();
    end else begin
      r.status = 1;
    end
    r.count = CNT_W'(shadow_set);
    r.frags = CFG_W'(shadow_frags);
    r.alloc = CNT_W'(shadow_frags * cell_lim);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 32'd1, 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_read_value !== e.value) report_mismatch("read_value", out_read_value, e.value);
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_element_count !== e.count)
          report_mismatch("element_count", out_element_count, e.count);
        if (out_active_fragment_count !== e.frags)
          report_mismatch("active_fragment_count", out_active_fragment_count, e.frags);
        if (out_allocated_cells !== e.alloc)
          report_mismatch("allocated_cells", out_allocated_cells, e.alloc);
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(logic [2:0] rq, logic [IDX_W-1:0] ix, logic [VALUE_W-1:0] kv);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rq;
    in_cell_index <= ix;
    in_key_value <= kv;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_request(rq, ix, kv));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] ri, logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_idx <= ri;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (ri == CFG_FRAG_TOTAL) frag_lim = clamp_reg(v);
    else cell_lim = clamp_reg(v);
    wipe_shadow();
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(REQ_SET, 10'd0, 32'h7FFF_FFFF);
    send_item(REQ_SET, 10'd1023, 32'h8000_0000);
    send_item(REQ_GET, 10'd0, '0);
    send_item(REQ_GET, 10'd1023, '0);
    send_item(REQ_GET, 10'd5, '0);
    send_item(REQ_ISSET, 10'd1023, '0);
    send_item(REQ_ISSET, 10'd5, '0);
    send_item(REQ_CONTAINS, 10'd0, 32'h8000_0000);
    send_item(REQ_CONTAINS, 10'd0, 32'd12345);
    send_item(REQ_SET, 10'd0, 32'hFFFF_FFFF);  // overwrite keeps counts
    send_item(REQ_GET, 10'd0, '0);
    send_item(REQ_DELETE, 10'd5, '0);          // empty cell
    send_item(REQ_DELETE, 10'd0, '0);
    send_item(REQ_DELETE, 10'd0, '0);
    send_item(REQ_DELETE, 10'd1023, '0);       // last cell frees fragment
    send_item(3'd6, 10'd3, 32'd1);
    send_item(3'd7, 10'd1023, 32'd1);
    send_item(REQ_SET, 10'd77, 32'd9);
    send_item(REQ_CLEAR, 10'd0, '0);
    send_item(REQ_GET, 10'd77, '0);
  endtask

  task automatic test_config_extremes();
    send_item(REQ_SET, 10'd3, 32'd1);
    write_reg(CFG_FRAG_TOTAL, 6'd0);   // reads as 1
    write_reg(CFG_CELLS, 6'd63);       // reads as 32
    send_item(REQ_SET, 10'd40, 32'd5); // out of range
    send_item(REQ_GET, 10'd40, '0);
    send_item(REQ_DELETE, 10'd40, '0);
    send_item(REQ_ISSET, 10'd40, '0);
    send_item(REQ_SET, 10'd31, 32'd5);
    send_item(REQ_CONTAINS, 10'd0, 32'd5);
    write_reg(CFG_FRAG_TOTAL, 6'd63);
    write_reg(CFG_CELLS, 6'd0);
    send_item(REQ_SET, 10'd31, 32'd6);
    send_item(REQ_ISSET, 10'd32, '0);
  endtask

  task automatic test_random(int n);
    int roll;
    int lim;
    logic [2:0] rq;
    logic [IDX_W-1:0] ix;
    logic [VALUE_W-1:0] kv;
    lim = frag_lim * cell_lim;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 35) rq = REQ_SET;
      else if (roll < 55) rq = REQ_GET;
      else if (roll < 78) rq = REQ_DELETE;
      else if (roll < 84) rq = REQ_CONTAINS;
      else if (roll < 95) rq = REQ_ISSET;
      else if (roll < 97) rq = REQ_CLEAR;
      else rq = 3'($urandom_range(6, 7));
      if ($urandom_range(9) == 0) ix = IDX_W'($urandom);
      else ix = IDX_W'($urandom_range(0, lim - 1));
      if ($urandom_range(3) == 0) kv = $urandom;
      else kv = VALUE_W'($urandom_range(0, 7)) ^ {VALUE_W{$urandom_range(1) == 1}};
      send_item(rq, ix, kv);
    end
  endtask

  task automatic test_backpressure();
    hold_req <= 1'b1;
    for (int i = 0; i < 20; i++)
      send_item(i % 2 ? REQ_GET : REQ_SET, IDX_W'(i), VALUE_W'(i * 3));
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_cell_index = '0;
    in_key_value = '0;
    hold_req = 0;
    error_count = 0;
    send_idle = 37;
    recv_idle = 68;
    frag_lim = 32;
    cell_lim = 32;
    wipe_shadow();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_backpressure();

    write_reg(CFG_FRAG_TOTAL, 6'd4);
    write_reg(CFG_CELLS, 6'd8);
    test_random(300);
    write_reg(CFG_FRAG_TOTAL, 6'd1);
    write_reg(CFG_CELLS, 6'd1);
    test_random(100);
    send_idle = 68;
    recv_idle = 37;
    write_reg(CFG_FRAG_TOTAL, 6'd32);
    write_reg(CFG_CELLS, 6'd1);
    test_random(300);
    write_reg(CFG_FRAG_TOTAL, 6'd3);
    write_reg(CFG_CELLS, 6'd5);
    test_random(300);
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_FRAG_TOTAL, 6'd1);
    write_reg(CFG_CELLS, 6'd32);
    test_random(300);
    write_reg(CFG_FRAG_TOTAL, 6'd32);
    write_reg(CFG_CELLS, 6'd32);
    test_random(300);

    wait_drained();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
